FILE: design/assert_macros.svh
// Assertion macros shared by the design files.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define AMCN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be true outside reset.
`define AMCN_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: design/amcn_pkg.sv
// Package for the affine matrix compose/normalize core: widths, codes, states.
// Operand index tables for the composition sequence. No dependencies.
package amcn_pkg;

	localparam int COEF_W = 32;
	localparam int FRAC_W = 16;
	localparam int PROD_W = 2 * COEF_W + 2;
	localparam int NUM_W  = COEF_W + FRAC_W;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic [2:0] mode_t;
	typedef logic [1:0] status_t;

	localparam mode_t MODE_NONE     = 3'd0;
	localparam mode_t MODE_BEFORE   = 3'd1;
	localparam mode_t MODE_AFTER    = 3'd2;
	localparam mode_t MODE_BEFORE_N = 3'd3;
	localparam mode_t MODE_AFTER_N  = 3'd4;
	localparam mode_t MODE_LOAD     = 3'd5;

	localparam status_t STAT_OK   = 2'd0;
	localparam status_t STAT_ANAM = 2'd1;
	localparam status_t STAT_ZERO = 2'd2;
	localparam status_t STAT_SAT  = 2'd3;

	localparam coef_t CMAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam coef_t CMIN = {1'b1, {(COEF_W-1){1'b0}}};
	localparam coef_t ONE  = coef_t'(1) <<< FRAC_W;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NCHK,
		ST_SQ_A,
		ST_SQ_C,
		ST_SQ_SUM,
		ST_SQRT_MUL,
		ST_SQRT_CMP,
		ST_DIV_LOAD,
		ST_DIV_RUN,
		ST_DIV_STORE,
		ST_MUL,
		ST_COMMIT,
		ST_DONE
	} state_t;

	// index of the first left-hand coefficient for result coefficient j
	function automatic logic [2:0] p_first(input logic [2:0] j);
		logic [2:0] r;
		case (j)
			3'd2, 3'd3: r = 3'd2;
			3'd4, 3'd5: r = 3'd4;
			default:    r = 3'd0;
		endcase
		return r;
	endfunction

	// index of the first right-hand coefficient for result coefficient j
	function automatic logic [2:0] q_first(input logic [2:0] j);
		return {2'b00, j[0]};
	endfunction

endpackage

FILE: design/affine_matrix_compose_normalize_core.sv
// Affine 2D matrix compose/normalize core, top level.
// Uses amcn_pkg and assert_macros.svh; one shared 33x33 multiplier, shared divider.
//
// Channel   Dir  Payload (low bit up)
// s_axis    in   tdata: t_a t_b t_c t_d t_e t_f; tuser: mode
// m_axis    out  tdata: m_a m_b m_c m_d m_e m_f status, zero pad to 200 bits
//
// None, load and unused modes go straight to the output stage. A compose runs
// twelve products on the shared multiplier. A normalized compose that is not
// rejected and not zero first divides by a single-axis scale, or by a square
// root found in 32 square-root steps, with four 48-step restoring divisions.
// Reset loads the identity matrix and empties the output register.
// A new item is taken while a result waits; it stalls only at the final hand-off.
module affine_matrix_compose_normalize_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [191:0] s_axis_tdata,  // t_a, t_b, t_c, t_d, t_e, t_f
	input  logic [2:0]   s_axis_tuser,  // mode
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [199:0] m_axis_tdata   // m_a .. m_f, status, pad
);

`include "assert_macros.svh"

	amcn_pkg::state_t state_q, state_d;

	amcn_pkg::coef_t tn_q [6];
	amcn_pkg::coef_t m_q [6];
	amcn_pkg::coef_t r_q [6];
	amcn_pkg::mode_t mode_q;
	amcn_pkg::status_t stat_q;
	logic sat_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [amcn_pkg::PROD_W-1:0] prod_q, acc_q;
	logic [63:0] sum_q;
	logic [31:0] k_q;
	logic kneg_q;
	logic [4:0] bit_q;
	logic [3:0] step_q;
	logic [1:0] div_idx_q;
	logic [5:0] cnt_q;
	logic [amcn_pkg::NUM_W-1:0] num_q, quot_q;
	logic [31:0] rem_q;
	logic dneg_q;
	logic [199:0] out_q;
	logic out_v_q;

	logic accept, t_first, rotscale, out_free;
	logic [31:0] cand;
	logic [2:0] j_iss, j_prev, pi, qi;
	logic [3:0] prev;
	amcn_pkg::coef_t pval, qval, addv;
	logic signed [amcn_pkg::PROD_W-1:0] sum66;
	logic signed [49:0] shifted;
	amcn_pkg::coef_t fin_val;
	logic fin_sat;
	logic [32:0] rem2;
	logic rem_ge;
	amcn_pkg::coef_t div_x, div_val;
	logic div_sat;
	logic [31:0] div_mag;
	logic [31:0] mag_a, mag_c;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_v_q || m_axis_tready;
	assign t_first  = (mode_q == amcn_pkg::MODE_BEFORE) || (mode_q == amcn_pkg::MODE_BEFORE_N);
	assign rotscale = (tn_q[0] == tn_q[3]) && (tn_q[1] != amcn_pkg::CMIN) &&
		(tn_q[2] == -tn_q[1]);
	assign mag_a    = tn_q[0][31] ? 32'(-tn_q[0]) : 32'(tn_q[0]);
	assign mag_c    = tn_q[2][31] ? 32'(-tn_q[2]) : 32'(tn_q[2]);
	assign cand     = k_q | (32'd1 << bit_q);

	// composition indices
	assign prev   = step_q - 4'd1;
	assign j_iss  = step_q[3:1];
	assign j_prev = prev[3:1];
	assign pi     = amcn_pkg::p_first(j_iss) + {2'b00, step_q[0]};
	assign qi     = amcn_pkg::q_first(j_iss) + {1'b0, step_q[0], 1'b0};
	assign pval   = t_first ? tn_q[pi] : m_q[pi];
	assign qval   = t_first ? m_q[qi] : tn_q[qi];

	always_comb begin
		case (j_prev)
			3'd4:    addv = t_first ? m_q[4] : tn_q[4];
			3'd5:    addv = t_first ? m_q[5] : tn_q[5];
			default: addv = '0;
		endcase
	end

	// finishing a sum of two products: floor shift, saturate
	assign sum66   = acc_q + prod_q;
	assign shifted = sum66[amcn_pkg::PROD_W-1:amcn_pkg::FRAC_W];
	always_comb begin
		fin_sat = 1'b0;
		fin_val = amcn_pkg::coef_t'(shifted);
		if (shifted > 50'(amcn_pkg::CMAX)) begin
			fin_sat = 1'b1;
			fin_val = amcn_pkg::CMAX;
		end else if (shifted < 50'(amcn_pkg::CMIN)) begin
			fin_sat = 1'b1;
			fin_val = amcn_pkg::CMIN;
		end
	end

	// divider step and result clamp
	assign rem2    = {rem_q, num_q[amcn_pkg::NUM_W-1]};
	assign rem_ge  = rem2 >= {1'b0, k_q};
	assign div_x   = tn_q[{1'b0, div_idx_q}];
	assign div_mag = div_x[31] ? 32'(-div_x) : 32'(div_x);
	always_comb begin
		div_sat = 1'b0;
		if (dneg_q) begin
			div_val = amcn_pkg::coef_t'(-quot_q[31:0]);
			if (quot_q > amcn_pkg::NUM_W'(33'h080000000)) begin
				div_sat = 1'b1;
				div_val = amcn_pkg::CMIN;
			end
		end else begin
			div_val = amcn_pkg::coef_t'(quot_q[31:0]);
			if (quot_q > amcn_pkg::NUM_W'(amcn_pkg::CMAX)) begin
				div_sat = 1'b1;
				div_val = amcn_pkg::CMAX;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			amcn_pkg::ST_IDLE: begin
				if (accept) begin
					if (s_axis_tuser == amcn_pkg::MODE_BEFORE_N ||
							s_axis_tuser == amcn_pkg::MODE_AFTER_N)
						state_d = amcn_pkg::ST_NCHK;
					else if (s_axis_tuser == amcn_pkg::MODE_BEFORE ||
							s_axis_tuser == amcn_pkg::MODE_AFTER)
						state_d = amcn_pkg::ST_MUL;
					else
						state_d = amcn_pkg::ST_DONE;
				end
			end
			amcn_pkg::ST_NCHK: begin
				if (!rotscale || (tn_q[0] == '0 && tn_q[2] == '0))
					state_d = amcn_pkg::ST_MUL;
				else if (tn_q[0] == '0 || tn_q[2] == '0)
					state_d = amcn_pkg::ST_DIV_LOAD;
				else
					state_d = amcn_pkg::ST_SQ_A;
			end
			amcn_pkg::ST_SQ_A:     state_d = amcn_pkg::ST_SQ_C;
			amcn_pkg::ST_SQ_C:     state_d = amcn_pkg::ST_SQ_SUM;
			amcn_pkg::ST_SQ_SUM:   state_d = amcn_pkg::ST_SQRT_MUL;
			amcn_pkg::ST_SQRT_MUL: state_d = amcn_pkg::ST_SQRT_CMP;
			amcn_pkg::ST_SQRT_CMP:
				state_d = (bit_q == '0) ? amcn_pkg::ST_DIV_LOAD : amcn_pkg::ST_SQRT_MUL;
			amcn_pkg::ST_DIV_LOAD: state_d = amcn_pkg::ST_DIV_RUN;
			amcn_pkg::ST_DIV_RUN:
				if (cnt_q == '0) state_d = amcn_pkg::ST_DIV_STORE;
			amcn_pkg::ST_DIV_STORE:
				state_d = (div_idx_q == 2'd3) ? amcn_pkg::ST_MUL : amcn_pkg::ST_DIV_LOAD;
			amcn_pkg::ST_MUL:
				if (step_q == 4'd12) state_d = amcn_pkg::ST_COMMIT;
			amcn_pkg::ST_COMMIT:   state_d = amcn_pkg::ST_DONE;
			amcn_pkg::ST_DONE:
				if (out_free) state_d = amcn_pkg::ST_IDLE;
			default:               state_d = amcn_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer: handshake and multiplier operands
	always_comb begin
		s_axis_tready = 1'b0;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			amcn_pkg::ST_IDLE: s_axis_tready = 1'b1;
			amcn_pkg::ST_SQ_A: begin
				mul_a = 33'(tn_q[0]);
				mul_b = 33'(tn_q[0]);
			end
			amcn_pkg::ST_SQ_C: begin
				mul_a = 33'(tn_q[2]);
				mul_b = 33'(tn_q[2]);
			end
			amcn_pkg::ST_SQRT_MUL: begin
				mul_a = {1'b0, cand};
				mul_b = {1'b0, cand};
			end
			amcn_pkg::ST_MUL: begin
				mul_a = 33'(pval);
				mul_b = 33'(qval);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= amcn_pkg::ST_IDLE;
			out_v_q <= 1'b0;
			for (int i = 0; i < 6; i++)
				m_q[i] <= (i == 0 || i == 3) ? amcn_pkg::ONE : '0;
		end else begin
			state_q <= state_d;
			if (state_q == amcn_pkg::ST_DONE && out_free) out_v_q <= 1'b1;
			else if (m_axis_tready) out_v_q <= 1'b0;
			if (accept && s_axis_tuser == amcn_pkg::MODE_LOAD)
				for (int i = 0; i < 6; i++) m_q[i] <= s_axis_tdata[32*i +: 32];
			if (state_q == amcn_pkg::ST_COMMIT)
				for (int i = 0; i < 6; i++) m_q[i] <= r_q[i];
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (state_q)
			amcn_pkg::ST_IDLE: begin
				if (accept) begin
					for (int i = 0; i < 6; i++) tn_q[i] <= s_axis_tdata[32*i +: 32];
					mode_q <= s_axis_tuser;
					stat_q <= amcn_pkg::STAT_OK;
					sat_q  <= 1'b0;
					step_q <= '0;
				end
			end
			amcn_pkg::ST_NCHK: begin
				div_idx_q <= '0;
				if (!rotscale)
					stat_q <= amcn_pkg::STAT_ANAM;
				else if (tn_q[0] == '0 && tn_q[2] == '0)
					stat_q <= amcn_pkg::STAT_ZERO;
				else if (tn_q[2] == '0) begin
					k_q    <= mag_a;
					kneg_q <= tn_q[0][31];
				end else begin
					k_q    <= mag_c;
					kneg_q <= tn_q[2][31];
				end
			end
			amcn_pkg::ST_SQ_C: acc_q <= prod_q;
			amcn_pkg::ST_SQ_SUM: begin
				sum_q  <= 64'(acc_q + prod_q);
				k_q    <= '0;
				kneg_q <= 1'b0;
				bit_q  <= 5'd31;
			end
			amcn_pkg::ST_SQRT_CMP: begin
				if (prod_q[63:0] <= sum_q) k_q <= cand;
				bit_q <= bit_q - 5'd1;
			end
			amcn_pkg::ST_DIV_LOAD: begin
				num_q  <= {div_mag, {amcn_pkg::FRAC_W{1'b0}}};
				rem_q  <= '0;
				quot_q <= '0;
				cnt_q  <= 6'(amcn_pkg::NUM_W - 1);
				dneg_q <= div_x[31] ^ kneg_q;
			end
			amcn_pkg::ST_DIV_RUN: begin
				rem_q  <= rem_ge ? 32'(rem2 - {1'b0, k_q}) : rem2[31:0];
				num_q  <= num_q << 1;
				quot_q <= {quot_q[amcn_pkg::NUM_W-2:0], rem_ge};
				cnt_q  <= cnt_q - 6'd1;
			end
			amcn_pkg::ST_DIV_STORE: begin
				tn_q[{1'b0, div_idx_q}] <= div_val;
				if (div_sat) sat_q <= 1'b1;
				div_idx_q <= div_idx_q + 2'd1;
			end
			amcn_pkg::ST_MUL: begin
				step_q <= step_q + 4'd1;
				if (step_q != '0) begin
					if (!prev[0])
						acc_q <= prod_q + {{(amcn_pkg::PROD_W-48){addv[31]}}, addv,
							{amcn_pkg::FRAC_W{1'b0}}};
					else begin
						r_q[j_prev] <= fin_val;
						if (fin_sat) sat_q <= 1'b1;
					end
				end
			end
			amcn_pkg::ST_DONE: begin
				if (out_free)
					out_q <= {6'b0, sat_q ? amcn_pkg::STAT_SAT : stat_q,
						m_q[5], m_q[4], m_q[3], m_q[2], m_q[1], m_q[0]};
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

	`AMCN_ASSERT(a_busy_after_accept, accept |=> !s_axis_tready, "item taken while busy")
	`AMCN_NEVER(a_div_zero, state_q == amcn_pkg::ST_DIV_RUN && k_q == '0, "divide by zero scale")
	`AMCN_ASSERT(a_sum_range, state_q == amcn_pkg::ST_SQRT_CMP |-> !sum_q[63], "sqrt operand range")

endmodule

FILE: test/tb_affine_matrix_compose_normalize_core.sv
// Testbench for affine_matrix_compose_normalize_core: directed table, then random items,
// checked against table values or an in-bench predictor of stored matrix and status.
// Depends on amcn_pkg and the core RTL only.
module tb_affine_matrix_compose_normalize_core;
	import amcn_pkg::*;

	typedef logic signed [79:0] wide_t;
	typedef struct {
		coef_t   m [6];
		status_t st;
	} matrix_result_t;
	typedef struct {
		mode_t   mode;
		coef_t   t [6];
		bit      typed;
		coef_t   m [6];
		status_t st;
	} table_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [191:0] s_axis_tdata;  // t_a, t_b, t_c, t_d, t_e, t_f
	logic [2:0]   s_axis_tuser;  // mode
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [199:0] m_axis_tdata;  // m_a .. m_f, status, pad

	coef_t          held [6];
	matrix_result_t pending_results [$];
	table_row_t     rows [$];
	int             fail_count;
	int             sent_items;
	int             got_items;
	int             snd_idle;
	int             rcv_idle;
	int             quiet_cycles;
	bit             done_sending;

	affine_matrix_compose_normalize_core uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic coef_t clamp_coef(wide_t v, inout bit sat);
		if (v > wide_t'(CMAX)) begin
			sat = 1'b1;
			return CMAX;
		end
		if (v < wide_t'(CMIN)) begin
			sat = 1'b1;
			return CMIN;
		end
		return coef_t'(v);
	endfunction

	function automatic coef_t prod_sum(coef_t p, coef_t q, coef_t r, coef_t s, coef_t add,
			inout bit sat);
		wide_t v;
		v = wide_t'(p) * wide_t'(q) + wide_t'(r) * wide_t'(s) + (wide_t'(add) <<< FRAC_W);
		return clamp_coef(v >>> FRAC_W, sat);
	endfunction

	function automatic coef_t scale_div(coef_t x, bit kneg, logic [63:0] kmag, inout bit sat);
		wide_t num;
		wide_t q;
		num = (x < 0) ? -wide_t'(x) : wide_t'(x);
		q = (num <<< FRAC_W) / wide_t'({1'b0, kmag});
		return clamp_coef(((x < 0) != kneg) ? -q : q, sat);
	endfunction

	function automatic void compose_into(coef_t p [6], coef_t q [6], inout bit sat);
		coef_t r [6];
		r[0] = prod_sum(p[0], q[0], p[1], q[2], '0, sat);
		r[1] = prod_sum(p[0], q[1], p[1], q[3], '0, sat);
		r[2] = prod_sum(p[2], q[0], p[3], q[2], '0, sat);
		r[3] = prod_sum(p[2], q[1], p[3], q[3], '0, sat);
		r[4] = prod_sum(p[4], q[0], p[5], q[2], q[4], sat);
		r[5] = prod_sum(p[4], q[1], p[5], q[3], q[5], sat);
		held = r;
	endfunction

	function automatic matrix_result_t apply_transform(mode_t mode, coef_t t_in [6]);
		matrix_result_t res;
		coef_t          t [6];
		bit             sat;
		bit             kneg;
		logic [63:0]    kmag;
		logic [63:0]    cand;
		logic [127:0]   sum;
		wide_t          amag;
		wide_t          cmag;
		t = t_in;
		sat = 1'b0;
		res.st = STAT_OK;
		if (mode == MODE_BEFORE_N || mode == MODE_AFTER_N) begin
			if (t[0] != t[3] || t[1] == CMIN || wide_t'(t[1]) + wide_t'(t[2]) != 0) begin
				res.st = STAT_ANAM;
			end else begin
				kneg = 1'b0;
				amag = (t[0] < 0) ? -wide_t'(t[0]) : wide_t'(t[0]);
				cmag = (t[2] < 0) ? -wide_t'(t[2]) : wide_t'(t[2]);
				if (t[2] == 0) begin
					kneg = t[0] < 0;
					kmag = amag[63:0];
				end else if (t[0] == 0) begin
					kneg = t[2] < 0;
					kmag = cmag[63:0];
				end else begin
					sum = 128'(amag[63:0]) * 128'(amag[63:0]) + 128'(cmag[63:0]) * 128'(cmag[63:0]);
					kmag = '0;
					for (int i = 63; i >= 0; i--) begin
						cand = kmag | (64'd1 << i);
						if (128'(cand) * 128'(cand) <= sum)
							kmag = cand;
					end
				end
				if (kmag == 0) begin
					res.st = STAT_ZERO;
				end else begin
					for (int i = 0; i < 4; i++)
						t[i] = scale_div(t[i], kneg, kmag, sat);
				end
			end
		end
		case (mode)
			MODE_BEFORE, MODE_BEFORE_N: compose_into(t, held, sat);
			MODE_AFTER, MODE_AFTER_N:   compose_into(held, t, sat);
			MODE_LOAD:                  held = t;
			default:                    ;
		endcase
		if (sat)
			res.st = STAT_SAT;
		res.m = held;
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch on result %0d: %s got %h expected %h", got_items, what, got, want);
		fail_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		matrix_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected item", m_axis_tdata[63:0], '0);
			end else begin
				want = pending_results.pop_front();
				for (int i = 0; i < 6; i++)
					if (m_axis_tdata[32*i +: 32] !== want.m[i])
						report_mismatch($sformatf("m[%0d]", i), 64'(m_axis_tdata[32*i +: 32]),
							64'($unsigned(want.m[i])));
				if (m_axis_tdata[193:192] !== want.st)
					report_mismatch("status", 64'(m_axis_tdata[193:192]), 64'(want.st));
			end
			got_items++;
		end
	end

	// receiver stalls
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= rcv_idle);

	// watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 5000 && arst_n) begin
			$display("watchdog expired after %0d items sent", sent_items);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic send_item(mode_t mode, coef_t t [6], bit typed, matrix_result_t typed_res);
		matrix_result_t res;
		while ($urandom_range(99) < snd_idle) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {t[5], t[4], t[3], t[2], t[1], t[0]};
		do
			@(posedge clk);
		while (!s_axis_tready);
		res = apply_transform(mode, t);
		pending_results.push_back(typed ? typed_res : res);
		sent_items++;
	endtask

	function automatic coef_t rand_coef();
		case ($urandom_range(3))
			0:       return coef_t'($urandom);
			1:       return coef_t'($signed($urandom_range(8 * 65536)) - 4 * 65536);
			2:       return coef_t'($signed($urandom_range(4096)) - 2048);
			default: return ($urandom_range(1)) ? ONE : -ONE;
		endcase
	endfunction

	task automatic add_row(mode_t mode, coef_t a, coef_t b, coef_t c, coef_t d, coef_t e, coef_t f,
			bit typed, status_t st);
		table_row_t row;
		row.mode = mode;
		row.t = '{a, b, c, d, e, f};
		row.typed = typed;
		if (mode == MODE_NONE)
			row.m = '{ONE, 0, 0, ONE, 0, 0};
		else
			row.m = row.t;
		row.st = st;
		rows.push_back(row);
	endtask

	initial begin
		table_row_t     row;
		matrix_result_t typed_res;
		coef_t          t [6];
		mode_t          mode;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = MODE_NONE;
		m_axis_tready = 1'b0;
		fail_count = 0;
		sent_items = 0;
		got_items = 0;
		quiet_cycles = 0;
		snd_idle = 16;
		rcv_idle = 74;
		held = '{ONE, 0, 0, ONE, 0, 0};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_row(MODE_NONE, 0, 0, 0, 0, 0, 0, 1, STAT_OK);
		add_row(MODE_LOAD, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 1, STAT_OK);
		add_row(MODE_NONE, CMIN, CMAX, 1, -1, 5, 7, 0, STAT_OK);
		add_row(3'd6, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0, STAT_OK);
		add_row(3'd7, -1, -1, -1, -1, -1, -1, 0, STAT_OK);
		add_row(MODE_BEFORE, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 0, STAT_OK);
		add_row(MODE_LOAD, ONE, 0, 0, ONE, 0, 0, 1, STAT_OK);
		add_row(MODE_AFTER_N, ONE, 0, 0, 2 * ONE, 3, 4, 1, STAT_ANAM);
		add_row(MODE_LOAD, ONE, 0, 0, ONE, 0, 0, 1, STAT_OK);
		add_row(MODE_AFTER_N, 0, 0, 0, 0, 0, 0, 1, STAT_ZERO);
		add_row(MODE_LOAD, -1, -1, -1, -1, 0, 0, 1, STAT_OK);
		add_row(MODE_AFTER_N, 2 * ONE, 0, 0, 2 * ONE, ONE, -ONE, 0, STAT_OK);
		add_row(MODE_BEFORE_N, -3 * ONE, 0, 0, -3 * ONE, 0, 0, 0, STAT_OK);
		add_row(MODE_AFTER_N, 0, ONE, -ONE, 0, 9, 9, 0, STAT_OK);
		add_row(MODE_BEFORE_N, 0, -5 * ONE, 5 * ONE, 0, 1, 2, 0, STAT_OK);
		add_row(MODE_AFTER_N, 3 * ONE, 4 * ONE, -4 * ONE, 3 * ONE, 0, 0, 0, STAT_OK);
		add_row(MODE_BEFORE_N, 1, 0, 0, 1, 0, 0, 0, STAT_OK);
		add_row(MODE_AFTER_N, CMAX, CMAX, -CMAX, CMAX, CMIN, CMAX, 0, STAT_OK);
		add_row(MODE_AFTER_N, ONE, CMIN, CMIN, ONE, 0, 0, 0, STAT_OK);
		add_row(MODE_AFTER, ONE, 0, 0, ONE, CMAX, CMIN, 0, STAT_OK);
		add_row(MODE_BEFORE, -ONE, ONE, ONE, ONE, 3, -3, 0, STAT_OK);
		foreach (rows[i]) begin
			row = rows[i];
			typed_res.m = row.m;
			typed_res.st = row.st;
			send_item(row.mode, row.t, row.typed, typed_res);
		end

		for (int n = 0; n < 1000; n++) begin
			if (n == 333) begin
				snd_idle = 74;
				rcv_idle = 16;
			end else if (n == 666) begin
				snd_idle = 0;
				rcv_idle = 0;
			end
			for (int i = 0; i < 6; i++)
				t[i] = rand_coef();
			mode = mode_t'($urandom_range(7));
			if ((mode == MODE_BEFORE_N || mode == MODE_AFTER_N) && $urandom_range(9) < 8) begin
				t[3] = t[0];
				t[2] = -t[1];
				if ($urandom_range(7) == 0)
					t[1] = 0;
				else if ($urandom_range(7) == 0)
					t[0] = 0;
				t[3] = t[0];
				t[2] = -t[1];
			end
			if ($urandom_range(15) == 0)
				mode = MODE_LOAD;
			send_item(mode, t, 1'b0, typed_res);
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		$display("%0d items sent, %0d results checked over three stall profiles",
			sent_items, got_items);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
